// ===== hw/rtl/lwa_pkg.sv =====
`timescale 1ns / 1ps
package lwa_pkg;

  localparam int CFG_SW_W   = 12;
  localparam int CFG_DW_W   = 11;
  localparam int CFG_DH_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 2'd2;

  localparam logic [CFG_SW_W-1:0] SW_RESET = 12'd720;
  localparam logic [CFG_DW_W-1:0] DW_RESET = 11'd720;
  localparam logic [CFG_DH_W-1:0] DH_RESET = 11'd576;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int LUMA_W  = 16;
  localparam int GREY_W  = 8;
  localparam int HIT_W   = 16;
  localparam int AMT_W   = 9;
  localparam int FRAC_W  = 8;
  localparam int DIV_M_W = 16;

  localparam logic [DIV_M_W-1:0] LUMA_FULL   = 16'hffff;
  localparam logic [HIT_W-1:0]   HIT_MAX     = 16'hffff;
  localparam logic [AMT_W-1:0]   FULL_AMOUNT = 9'd256;
  localparam logic [AMT_W-1:0]   CONN_AMOUNT = 9'd64;

  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;
  localparam logic [Q_CNT_W-1:0] Q_DEPTH = 2'd2;

  typedef struct packed {
    logic              op;
    logic [LUMA_W-1:0] luma;
    logic              frame_start;
  } lwa_cmd_t;

endpackage

// ===== hw/rtl/luma_waveform_accumulator_core.sv =====
// An accepted beat is registered into a two-beat queue that keeps input open; the back end
// pops it when idle. Read beat: the pixel is read, held while the output stalls, registered
// onto the output, and its entry cleared. Accumulate beat: one update for the sample row, one
// for the row above unless the sample row is the top one, one per connector row when an earlier
// sample of the line exists; the one-bit-per-cycle column divider runs before the updates.
// Reset is synchronous; then the store clears one entry per cycle (1048576 entries by default).
`timescale 1ns / 1ps
module luma_waveform_accumulator_core
  import lwa_pkg::*;
#(
  parameter int MAX_DISPLAY_WIDTH  = 1024,
  parameter int MAX_DISPLAY_HEIGHT = 1024,
  parameter int MAX_SOURCE_WIDTH   = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [LUMA_W-1:0]     s_tdata,   // luma
  input  logic [1:0]            s_tuser,   // bit 0 action, bit 1 frame_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [GREY_W-1:0]     m_tdata,   // grey
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW_HI = (MAX_SOURCE_WIDTH > (1 << CFG_SW_W) - 1) ?
                         (1 << CFG_SW_W) - 1 : MAX_SOURCE_WIDTH;
  localparam int DW_HI = (MAX_DISPLAY_WIDTH > (1 << CFG_DW_W) - 1) ?
                         (1 << CFG_DW_W) - 1 : MAX_DISPLAY_WIDTH;
  localparam int DH_HI = (MAX_DISPLAY_HEIGHT > (1 << CFG_DH_W) - 1) ?
                         (1 << CFG_DH_W) - 1 : MAX_DISPLAY_HEIGHT;

  logic [CFG_SW_W-1:0] source_width;
  logic [CFG_DW_W-1:0] display_width;
  logic [CFG_DH_W-1:0] display_height;
  logic [CFG_SW_W-1:0] sw_eff;
  logic [CFG_DW_W-1:0] dw_eff;
  logic [CFG_DH_W-1:0] dh_eff;
  logic                clearing;
  logic                cmd_valid;
  logic                cmd_pop;
  lwa_cmd_t            cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width   <= SW_RESET;
      display_width  <= DW_RESET;
      display_height <= DH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:   source_width   <= cfg_data[CFG_SW_W-1:0];
        REG_DISPLAY_WIDTH:  display_width  <= cfg_data[CFG_DW_W-1:0];
        REG_DISPLAY_HEIGHT: display_height <= cfg_data[CFG_DH_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values are clamped where they are used.
  always_comb begin
    sw_eff = source_width;
    if (source_width == '0) begin
      sw_eff = CFG_SW_W'(1);
    end else if (32'(source_width) > SW_HI) begin
      sw_eff = CFG_SW_W'(SW_HI);
    end
    dw_eff = display_width;
    if (display_width < CFG_DW_W'(2)) begin
      dw_eff = CFG_DW_W'(2);
    end else if (32'(display_width) > DW_HI) begin
      dw_eff = CFG_DW_W'(DW_HI);
    end
    dh_eff = display_height;
    if (display_height < CFG_DH_W'(2)) begin
      dh_eff = CFG_DH_W'(2);
    end else if (32'(display_height) > DH_HI) begin
      dh_eff = CFG_DH_W'(DH_HI);
    end
  end

  lwa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .hold      (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lwa_back #(
    .MAX_DISPLAY_WIDTH  (MAX_DISPLAY_WIDTH),
    .MAX_DISPLAY_HEIGHT (MAX_DISPLAY_HEIGHT),
    .MAX_SOURCE_WIDTH   (MAX_SOURCE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .sw_eff    (sw_eff),
    .dw_eff    (dw_eff),
    .dh_eff    (dh_eff),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_grey  (m_tdata),
    .out_last  (m_tlast)
  );

  a_clear_after_reset: assert property (@(posedge clk) rst |=> clearing)
    else $error("store clearing pass did not start after reset");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input beat offered ready during the clearing pass");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_pop)
    else $error("queue popped during the clearing pass");

endmodule

// ===== hw/rtl/lwa_front.sv =====
`timescale 1ns / 1ps
module lwa_front
  import lwa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [LUMA_W-1:0] s_tdata,   // luma
  input  logic [1:0]        s_tuser,   // bit 0 action, bit 1 frame_start
  input  logic              hold,
  output logic              cmd_valid,
  output lwa_cmd_t          cmd,
  input  logic              cmd_pop
);

  lwa_cmd_t             q_mem [2];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  lwa_cmd_t             cmd_in;
  logic                 push;
  logic                 pop;

  // A frame mark only means something on an accumulate beat.
  always_comb begin
    cmd_in.op          = s_tuser[0];
    cmd_in.luma        = s_tdata;
    cmd_in.frame_start = s_tuser[1] && (s_tuser[0] == OP_ACCUM);
  end

  assign s_tready  = (count != Q_DEPTH) && !hold;
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/lwa_div.sv =====
`timescale 1ns / 1ps
module lwa_div
  import lwa_pkg::*;
#(
  parameter int N = 35,
  parameter int M = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [M-1:0]     dvs;
  logic [M-1:0]     rem;
  logic [N-1:0]     quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [M:0]       rem_sh;
  logic [M:0]       diff;
  logic             fits;

  assign rem_sh   = {rem, quo[N-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvs  <= divisor;
        rem  <= '0;
        quo  <= dividend;
        cnt  <= CNT_W'(N);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[M-1:0] : rem_sh[M-1:0];
        quo <= {quo[N-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/lwa_back.sv =====
`timescale 1ns / 1ps
module lwa_back
  import lwa_pkg::*;
#(
  parameter int MAX_DISPLAY_WIDTH  = 1024,
  parameter int MAX_DISPLAY_HEIGHT = 1024,
  parameter int MAX_SOURCE_WIDTH   = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CFG_SW_W-1:0] sw_eff,
  input  logic [CFG_DW_W-1:0] dw_eff,
  input  logic [CFG_DH_W-1:0] dh_eff,
  input  logic                cmd_valid,
  input  lwa_cmd_t            cmd,
  output logic                cmd_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GREY_W-1:0]   out_grey,
  output logic                out_last
);

  localparam int COL_W  = $clog2(MAX_DISPLAY_WIDTH);
  localparam int ROW_W  = $clog2(MAX_DISPLAY_HEIGHT);
  localparam int DEPTH  = MAX_DISPLAY_WIDTH * MAX_DISPLAY_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CCOL_W = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int PROD_W = CCOL_W + CFG_DW_W;
  localparam int SC_W   = CFG_DH_W + FRAC_W;
  localparam int SCP_W  = LUMA_W + SC_W;
  localparam int DVD_W  = PROD_W;
  localparam int TOT_W  = CFG_DW_W + CFG_DH_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DX    = 4'd2;
  localparam logic [3:0] S_SC    = 4'd3;
  localparam logic [3:0] S_ROW   = 4'd4;
  localparam logic [3:0] S_ADDR  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_RRD   = 4'd8;
  localparam logic [3:0] S_RWR   = 4'd9;

  localparam logic [1:0] PH_MAIN  = 2'd0;
  localparam logic [1:0] PH_ABOVE = 2'd1;
  localparam logic [1:0] PH_CONN  = 2'd2;

  logic [HIT_W-1:0]  mem [DEPTH];
  logic [HIT_W-1:0]  rd_data;
  logic              mem_we;
  logic              mem_re;
  logic [HIT_W-1:0]  mem_wdata;

  logic [3:0]        state;
  logic [ADDR_W-1:0] addr;
  logic [CCOL_W-1:0] col_cnt;
  logic [ROW_W-1:0]  prev_row;
  logic              prev_valid;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CCOL_W-1:0] col_use;
  logic              pv_use;
  logic [LUMA_W-1:0] luma_r;
  logic [COL_W-1:0]  dx_r;
  logic [ROW_W-1:0]  row_r;
  logic [FRAC_W-1:0] frac_r;
  logic [ROW_W-1:0]  cur_row;
  logic [AMT_W-1:0]  amount;
  logic [1:0]        phase;
  logic [ROW_W-1:0]  first_r;
  logic [ROW_W-1:0]  last_r;
  logic              last_pix;
  logic [SCP_W-1:0]  prod_r;
  logic [SC_W-1:0]   scaled_r;

  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [DIV_M_W-1:0] div_divisor;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;

  logic              restart;
  logic [CCOL_W-1:0] col_use_n;
  logic [TOT_W-1:0]  total;
  logic [ADDR_W-1:0] rd_p;
  logic [CFG_DH_W-1:0] dh_m1;
  logic [CFG_DH_W-1:0] row_full;
  logic [ROW_W-1:0]  row_n;
  logic [ROW_W-1:0]  prev_c;
  logic [HIT_W:0]    sum;
  logic [HIT_W-1:0]  sat_sum;
  logic [GREY_W-1:0] grey_n;
  logic              out_free;
  logic [SC_W-1:0]   sc_hi;
  logic [SC_W:0]     sc_fold;
  logic [LUMA_W:0]   sc_low;
  logic              sc_adj;
  logic [SC_W-1:0]   scaled_n;

  assign clearing = (state == S_CLEAR);
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign out_free = !out_valid || out_ready;

  assign restart   = cmd.frame_start || (32'(col_cnt) >= 32'(sw_eff));
  assign col_use_n = restart ? '0 : col_cnt;
  assign total     = TOT_W'(dw_eff * dh_eff);
  assign rd_p      = (32'(rd_ptr) >= 32'(total)) ? '0 : rd_ptr;
  assign dh_m1     = dh_eff - 1'b1;
  assign row_full  = dh_m1 - scaled_r[SC_W-1:FRAC_W];
  assign row_n     = ROW_W'(row_full);
  assign prev_c    = (32'(prev_row) > 32'(dh_m1)) ? ROW_W'(dh_m1) : prev_row;

  // Division by 65535 folds the upper half of the product back onto the lower half,
  // since 2^16 is one more than the divisor.
  assign sc_hi    = prod_r[SCP_W-1:LUMA_W];
  assign sc_fold  = {1'b0, sc_hi} + (SC_W + 1)'(prod_r[LUMA_W-1:0]);
  assign sc_low   = {1'b0, sc_fold[LUMA_W-1:0]} + (LUMA_W + 1)'(sc_fold[SC_W:LUMA_W]);
  assign sc_adj   = sc_low >= {1'b0, LUMA_FULL};
  assign scaled_n = sc_hi + SC_W'(sc_fold[SC_W:LUMA_W]) + SC_W'(sc_adj);

  assign sum     = {1'b0, rd_data} + (HIT_W + 1)'(amount);
  assign sat_sum = sum[HIT_W] ? HIT_MAX : sum[HIT_W-1:0];
  assign grey_n  = (rd_data[15:13] != 3'b000) ? 8'hff : {rd_data[12:8], 3'b000};

  assign div_start    = cmd_pop && (cmd.op == OP_ACCUM);
  assign div_dividend = DVD_W'(col_use_n * dw_eff);
  assign div_divisor  = DIV_M_W'(sw_eff);

  lwa_div #(
    .N(DVD_W),
    .M(DIV_M_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign mem_we    = (state == S_CLEAR) || (state == S_WR) || ((state == S_RWR) && out_free);
  assign mem_re    = (state == S_RD) || (state == S_RRD);
  assign mem_wdata = (state == S_WR) ? sat_sum : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      col_cnt    <= '0;
      prev_row   <= '0;
      prev_valid <= 1'b0;
      rd_ptr     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_RWR) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_READ) begin
              addr     <= rd_p;
              last_pix <= (32'(rd_p) == 32'(total) - 1);
              state    <= S_RRD;
            end else begin
              col_use <= col_use_n;
              pv_use  <= prev_valid && !restart;
              luma_r  <= cmd.luma;
              state   <= S_DX;
            end
          end
        end
        S_DX: begin
          prod_r <= SCP_W'(luma_r * {dh_m1, 8'h00});
          if (div_done) begin
            dx_r  <= COL_W'(div_quo);
            state <= S_SC;
          end
        end
        S_SC: begin
          scaled_r <= scaled_n;
          state    <= S_ROW;
        end
        S_ROW: begin
          row_r   <= row_n;
          frac_r  <= scaled_r[FRAC_W-1:0];
          cur_row <= row_n;
          amount  <= FULL_AMOUNT - AMT_W'(scaled_r[FRAC_W-1:0]);
          phase   <= PH_MAIN;
          first_r <= (prev_c < row_n) ? prev_c : row_n;
          last_r  <= (prev_c < row_n) ? row_n : prev_c;
          // The line ends after its last source sample.
          if (32'(col_use) + 1 >= 32'(sw_eff)) begin
            col_cnt    <= '0;
            prev_valid <= 1'b0;
            prev_row   <= '0;
          end else begin
            col_cnt    <= col_use + 1'b1;
            prev_valid <= 1'b1;
            prev_row   <= row_n;
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr  <= ADDR_W'(cur_row * dw_eff + dx_r);
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if ((phase == PH_MAIN) && (row_r != '0)) begin
            cur_row <= row_r - 1'b1;
            amount  <= AMT_W'(frac_r);
            phase   <= PH_ABOVE;
            state   <= S_ADDR;
          end else if (phase == PH_CONN) begin
            if (cur_row == last_r) begin
              state <= S_IDLE;
            end else begin
              cur_row <= cur_row + 1'b1;
              state   <= S_ADDR;
            end
          end else if (pv_use) begin
            cur_row <= first_r;
            amount  <= CONN_AMOUNT;
            phase   <= PH_CONN;
            state   <= S_ADDR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RRD: begin
          state <= S_RWR;
        end
        S_RWR: begin
          if (out_free) begin
            out_grey  <= grey_n;
            out_last  <= last_pix;
            rd_ptr    <= last_pix ? '0 : addr + 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
